// File: rtl/ps2rx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receiver package
// Shared constants and types for the PS/2 receive deserializer and its queue.
// ----------------------------------------------------------------------------
package ps2rx_pkg;

  localparam int unsigned QUEUE_DEPTH_DFLT = 32;

  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd2000;

  // Frame bit positions: idle waits for the start bit, then data, parity, stop.
  localparam logic [3:0] POS_IDLE       = 4'd0;
  localparam logic [3:0] POS_FIRST_DATA = 4'd1;
  localparam logic [3:0] POS_LAST_DATA  = 4'd8;
  localparam logic [3:0] POS_PARITY     = 4'd9;
  localparam logic [3:0] POS_STOP       = 4'd10;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_STORED   = 2'd1,
    ST_BAD_STOP = 2'd2,
    ST_FULL     = 2'd3
  } frame_status_t;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_POP  = 1'b1
  } req_type_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic nonempty_after;
  } fifo_stat_t;

endpackage

// File: rtl/ps2rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receiver channel interfaces
// Valid/ready channels for requests into the receiver and results out of it.
// ----------------------------------------------------------------------------
interface ps2rx_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        data_bit;
  logic [31:0] time_us;

  modport source (output valid, req_type, data_bit, time_us, input ready);
  modport sink   (input valid, req_type, data_bit, time_us, output ready);
endinterface

interface ps2rx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       queue_nonempty;
  logic [1:0] frame_status;

  modport source (output valid, read_byte, read_valid, queue_nonempty, frame_status,
                  input ready);
  modport sink   (input valid, read_byte, read_valid, queue_nonempty, frame_status,
                  output ready);
endinterface

// File: rtl/ps2rx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receiver byte queue
// Ring queue that keeps one slot free, with a registered read port.
// ----------------------------------------------------------------------------
module ps2rx_fifo
  import ps2rx_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] push_data,
  input  logic       pop,
  output logic [7:0] rd_data,
  output fifo_stat_t stat
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_inc, rd_inc;

  assign wr_inc = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;

  always_comb begin
    wr_idx_nxt = push ? wr_inc : wr_idx_r;
    rd_idx_nxt = pop  ? rd_inc : rd_idx_r;
  end

  assign stat.empty          = (wr_idx_r == rd_idx_r);
  assign stat.full           = (wr_inc == rd_idx_r);
  assign stat.nonempty_after = (wr_idx_nxt != rd_idx_nxt);
  assign rd_data             = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_idx_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into a full queue");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && pop))
    else $error("push and pop in the same cycle");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (wr_idx_r != rd_idx_r))
    else $error("queue empty right after a push");

endmodule

// File: rtl/ps2_receive_deserializer_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receive deserializer with byte queue
// Assembles PS/2 frames from sampled falling clock edges and queues good
// bytes; pop requests read the queue.
// ----------------------------------------------------------------------------
// Timing: each result is registered and appears on out_chan in the cycle after its request transfer.
// Throughput: one request per cycle; the input stalls only while a finished
// result is still waiting on out_chan.
// Reset: synchronous and active low; the frame restarts, the queue is empty,
// the last edge time is zero and the gap timeout returns to 2000 us.
// ----------------------------------------------------------------------------
module ps2_receive_deserializer_fifo_unit
  import ps2rx_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  ps2rx_in_if.sink     in_chan,
  ps2rx_out_if.source  out_chan
);

  logic [15:0]   gap_timeout_r;
  logic [3:0]    bit_pos_r, bit_pos_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [31:0]   last_edge_r;

  logic          out_valid_r;
  logic          out_read_valid_r, out_read_valid_nxt;
  logic          out_nonempty_r;
  frame_status_t out_status_r, status_nxt;

  logic          in_accept, edge_acc, pop_acc;
  logic [31:0]   gap;
  logic          timed_out;
  logic [3:0]    pos_eff, pos_m1;
  logic [7:0]    shift_eff;
  logic          push;
  logic [7:0]    fifo_rd_data;
  fifo_stat_t    fifo_stat;

  // The output register parts the two sides; a new request moves in as the
  // waiting result is taken.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign edge_acc      = in_accept && (in_chan.req_type == REQ_EDGE);
  assign pop_acc       = in_accept && (in_chan.req_type == REQ_POP) && !fifo_stat.empty;

  // A long gap since the previous edge abandons any partial frame.
  assign gap       = in_chan.time_us - last_edge_r;
  assign timed_out = gap > {16'd0, gap_timeout_r};
  assign pos_eff   = timed_out ? POS_IDLE : bit_pos_r;
  assign shift_eff = timed_out ? 8'd0 : shift_r;
  assign pos_m1    = pos_eff - POS_FIRST_DATA;

  always_comb begin
    bit_pos_nxt = pos_eff;
    shift_nxt   = shift_eff;
    status_nxt  = ST_NONE;
    push        = 1'b0;
    case (pos_eff) inside
      POS_IDLE: begin
        if (!in_chan.data_bit) begin
          shift_nxt   = 8'd0;
          bit_pos_nxt = POS_FIRST_DATA;
        end
      end
      [POS_FIRST_DATA:POS_LAST_DATA]: begin
        shift_nxt[pos_m1[2:0]] = shift_eff[pos_m1[2:0]] | in_chan.data_bit;
        bit_pos_nxt            = pos_eff + 4'd1;
      end
      POS_PARITY: begin
        bit_pos_nxt = POS_STOP;
      end
      default: begin
        bit_pos_nxt = POS_IDLE;
        if (!in_chan.data_bit) begin
          status_nxt = ST_BAD_STOP;
        end else if (fifo_stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_STORED;
          push       = edge_acc;
        end
      end
    endcase
  end

  assign out_read_valid_nxt = pop_acc;

  ps2rx_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (shift_eff),
    .pop       (pop_acc),
    .rd_data   (fifo_rd_data),
    .stat      (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_timeout_r <= GAP_TIMEOUT_RESET;
    end else if (cfg_we) begin
      gap_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r   <= POS_IDLE;
      shift_r     <= 8'd0;
      last_edge_r <= 32'd0;
    end else if (edge_acc) begin
      bit_pos_r   <= bit_pos_nxt;
      shift_r     <= shift_nxt;
      last_edge_r <= in_chan.time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_valid_r <= out_read_valid_nxt;
      out_nonempty_r   <= fifo_stat.nonempty_after;
      out_status_r     <= edge_acc ? status_nxt : ST_NONE;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.read_byte      = out_read_valid_r ? fifo_rd_data : 8'd0;
  assign out_chan.read_valid     = out_read_valid_r;
  assign out_chan.queue_nonempty = out_nonempty_r;
  assign out_chan.frame_status   = out_status_r;

  a_pop_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.read_valid) |-> (out_chan.frame_status == ST_NONE))
    else $error("pop result carries a frame status");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_pos_r <= POS_STOP)
    else $error("frame bit position out of range");

  a_pop_returns: assert property (@(posedge clk) disable iff (!rst_n)
    pop_acc |=> (out_chan.valid && out_chan.read_valid))
    else $error("pop of a nonempty queue returned no byte");

endmodule

// File: verif/ps2rx_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receiver result checker
// Watches the request and result channels of the PS/2 receive deserializer.
// It keeps its own copy of the frame state, the byte queue and the gap
// timeout. Every result transfer is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module ps2rx_result_checker
  import ps2rx_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ps2rx_in_if         in_mon,
  ps2rx_out_if        out_mon,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0]    rd_byte;
    logic          rd_valid;
    logic          nonempty;
    frame_status_t status;
  } rx_result_t;

  rx_result_t   rx_expected_q[$];

  logic [15:0]  gap_limit;
  logic [3:0]   bit_pos;
  logic [7:0]   shift_reg;
  logic [31:0]  last_stamp;
  logic [7:0]   byte_mem [DEPTH];
  int unsigned  wr_ptr;
  int unsigned  rd_ptr;

  function automatic int unsigned ring_inc(int unsigned ptr);
    return (ptr + 1 >= DEPTH) ? 0 : ptr + 1;
  endfunction

  // Advances the predicted state by one request and returns its result.
  function automatic rx_result_t predict_rx_result(req_type_t req, logic dbit,
                                                   logic [31:0] stamp);
    rx_result_t  res;
    logic [31:0] gap;
    res        = '0;
    res.status = ST_NONE;
    if (req == REQ_EDGE) begin
      gap = stamp - last_stamp;
      if (gap > {16'd0, gap_limit}) begin
        bit_pos   = POS_IDLE;
        shift_reg = '0;
      end
      last_stamp = stamp;
      if (bit_pos == POS_IDLE) begin
        // A high level while idle is not a start bit.
        if (!dbit) begin
          shift_reg = '0;
          bit_pos   = POS_FIRST_DATA;
        end
      end else if (bit_pos <= POS_LAST_DATA) begin
        shift_reg[bit_pos - POS_FIRST_DATA] = dbit;
        bit_pos = bit_pos + 4'd1;
      end else if (bit_pos == POS_PARITY) begin
        bit_pos = POS_STOP;
      end else begin
        if (!dbit) begin
          res.status = ST_BAD_STOP;
        end else if (ring_inc(wr_ptr) == rd_ptr) begin
          res.status = ST_FULL;
        end else begin
          byte_mem[wr_ptr] = shift_reg;
          wr_ptr           = ring_inc(wr_ptr);
          res.status       = ST_STORED;
        end
        bit_pos = POS_IDLE;
      end
    end else if (wr_ptr != rd_ptr) begin
      res.rd_byte  = byte_mem[rd_ptr];
      res.rd_valid = 1'b1;
      rd_ptr       = ring_inc(rd_ptr);
    end
    res.nonempty = (wr_ptr != rd_ptr);
    return res;
  endfunction

  always @(posedge clk) begin
    rx_result_t want;
    rx_result_t got;
    if (!rst_n) begin
      gap_limit   = GAP_TIMEOUT_RESET;
      bit_pos     = POS_IDLE;
      shift_reg   = '0;
      last_stamp  = '0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      mismatches  = 0;
      rx_expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.rd_byte  = out_mon.read_byte;
        got.rd_valid = out_mon.read_valid;
        got.nonempty = out_mon.queue_nonempty;
        got.status   = frame_status_t'(out_mon.frame_status);
        if (rx_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: byte %02h valid %0d nonempty %0d status %0d",
                     got.rd_byte, got.rd_valid, got.nonempty, got.status);
        end else begin
          want = rx_expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t:", $realtime);
              $display("  expected byte %02h valid %0d nonempty %0d status %0d",
                       want.rd_byte, want.rd_valid, want.nonempty, want.status);
              $display("  actual   byte %02h valid %0d nonempty %0d status %0d",
                       got.rd_byte, got.rd_valid, got.nonempty, got.status);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        rx_expected_q.push_back(predict_rx_result(req_type_t'(in_mon.req_type),
                                                  in_mon.data_bit, in_mon.time_us));
      if (cfg_we)
        gap_limit = cfg_wdata;
    end
    outstanding = rx_expected_q.size();
  end

endmodule

// File: verif/ps2_receive_deserializer_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 receive deserializer testbench
// Drives clock edge samples and pop requests with random idle cycles and
// result back-pressure, across several gap timeout settings. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ps2_receive_deserializer_fifo_unit_tb
  import ps2rx_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  ps2rx_in_if  in_ch ();
  ps2rx_out_if out_ch ();

  int          mismatches;
  int          outstanding;

  logic        calm;
  logic        hold_go;
  logic [15:0] gap_setting;
  logic [31:0] now_us;
  bit          force_gap;
  bit          gap_faults;
  int unsigned items_sent;

  ps2_receive_deserializer_fifo_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_ch),
    .out_chan  (out_ch)
  );

  ps2rx_result_checker u_result_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Next edge timestamp; mostly inside the gap timeout, sometimes past it.
  function automatic logic [31:0] next_stamp(bit overlong);
    int unsigned pick;
    logic [31:0] delta;
    pick = $urandom_range(99);
    if (overlong || (gap_faults && pick < 3))
      delta = 32'(gap_setting) + 32'd1 + $urandom_range(0, 100000);
    else if (gap_faults && pick < 4)
      delta = $urandom();
    else if (pick < 12)
      delta = 32'(gap_setting);
    else
      delta = $urandom_range(0, gap_setting);
    now_us = now_us + delta;
    return now_us;
  endfunction

  task automatic send_item(req_type_t req, logic dbit, logic [31:0] stamp);
    if (!calm && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.data_bit <= dbit;
    in_ch.time_us  <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_edge(logic dbit);
    logic [31:0] stamp;
    stamp     = next_stamp(force_gap);
    force_gap = 0;
    send_item(REQ_EDGE, dbit, stamp);
  endtask

  // The data bit and timestamp of a pop are don't-care, so they are random.
  task automatic send_pop();
    send_item(REQ_POP, 1'($urandom_range(1)), $urandom());
  endtask

  // Start bit, eight data bits LSB first, parity, stop; may be cut short.
  task automatic send_frame(logic [7:0] payload, logic stop_bit, int unsigned edge_count);
    logic dbit;
    for (int unsigned i = 0; i < edge_count; i++) begin
      if (i == 0)
        dbit = 1'b0;
      else if (i <= 8)
        dbit = payload[i - 1];
      else if (i == 9)
        dbit = 1'($urandom_range(1));
      else
        dbit = stop_bit;
      send_edge(dbit);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gap_timeout(logic [15:0] value);
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    gap_setting = value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned quota);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(8'($urandom()), 1'b1, 11);
      end else if (pick < 63) begin
        send_frame(8'($urandom()), 1'b0, 11);
      end else if (pick < 68) begin
        // A cut-off frame, abandoned by a long gap before the next edge.
        send_frame(8'($urandom()), 1'($urandom()), $urandom_range(1, 10));
        force_gap = 1;
      end else if (pick < 73) begin
        send_edge(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 3)) send_pop();
      end
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_EDGE;
    in_ch.data_bit = 1'b0;
    in_ch.time_us  = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    calm           = 1'b0;
    hold_go        = 1'b0;
    gap_setting    = GAP_TIMEOUT_RESET;
    now_us         = 32'd100;
    force_gap      = 0;
    gap_faults     = 0;
    items_sent     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pop, idle-high edge, all-ones byte, all-zero byte with a bad stop.
    send_pop();
    send_edge(1'b1);
    send_frame(8'hFF, 1'b1, 11);
    send_frame(8'h00, 1'b0, 11);
    send_pop();
    drain();

    gap_faults = 1;
    set_gap_timeout(16'd0);
    random_traffic(250);
    drain();

    // Widest timeout, timestamps wrapping; fill the queue past full, then
    // empty it past empty.
    set_gap_timeout(16'hFFFF);
    now_us     = 32'hFFFF_8000;
    gap_faults = 0;
    repeat (34) send_frame(8'($urandom()), 1'b1, 11);
    repeat (33) send_pop();
    gap_faults = 1;
    hold_go <= 1'b1;
    random_traffic(250);
    drain();

    set_gap_timeout(16'($urandom_range(1, 65534)));
    calm <= 1'b1;
    random_traffic(150);
    calm <= 1'b0;
    random_traffic(150);
    drain();

    set_gap_timeout(16'd50);
    random_traffic(250);
    drain();

    set_gap_timeout(GAP_TIMEOUT_RESET);
    random_traffic(220);
    drain();

    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
